/* rtl/psa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psa_pkg: shared types and codes of the process slot allocator
// Command and status codes and the control structs passed between the
// ready ring and the top level.
// ----------------------------------------------------------------------------
package psa_pkg;

  localparam int SlotsDefault = 16;

  typedef enum logic {
    CMD_CREATE   = 1'b0,
    CMD_DISPATCH = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_REUSED = 2'd1,
    STAT_EMPTY  = 2'd2,
    STAT_FULL   = 2'd3
  } status_e;

  // Ring update requests from the sequencer.
  typedef struct packed {
    logic push;
    logic pop;
  } ring_cmd_t;

  // Ring occupancy flags.
  typedef struct packed {
    logic empty;
    logic full;
  } ring_stat_t;

endpackage

/* rtl/psa_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psa_if: channel interfaces of the process slot allocator
// psa_in_if carries command transactions, psa_out_if carries result
// transactions. Both use a valid/ready handshake.
// ----------------------------------------------------------------------------
interface psa_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] table_base;

  modport source (output valid, cmd, table_base, input ready);
  modport sink   (input valid, cmd, table_base, output ready);
endinterface

interface psa_out_if #(
  parameter int SLOT_W = $clog2(psa_pkg::SlotsDefault)
);
  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] slot;
  logic [31:0]       proc_id;
  logic [31:0]       slot_table_base;
  logic [1:0]        status;

  modport source (output valid, slot, proc_id, slot_table_base, status, input ready);
  modport sink   (input valid, slot, proc_id, slot_table_base, status, output ready);
endinterface

/* rtl/psa_ready_ring.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psa_ready_ring: FIFO of ready slot indices
// A ring memory with head, tail and count registers. The entry at the head
// is read every cycle into a registered read port.
// ----------------------------------------------------------------------------
module psa_ready_ring #(
  parameter int SLOTS = psa_pkg::SlotsDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  psa_pkg::ring_cmd_t       cmd_i,
  input  logic [$clog2(SLOTS)-1:0] push_slot_i,
  output logic [$clog2(SLOTS)-1:0] head_slot_o,
  output psa_pkg::ring_stat_t      stat_o
);

  localparam int SlotW = $clog2(SLOTS);
  localparam int CntW  = $clog2(SLOTS + 1);
  localparam logic [SlotW-1:0] LastIdx = SlotW'(SLOTS - 1);
  localparam logic [CntW-1:0]  FullCnt = CntW'(SLOTS);

  logic [SlotW-1:0] ring_mem [SLOTS];
  logic [SlotW-1:0] head_q, head_d;
  logic [SlotW-1:0] tail_q, tail_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [SlotW-1:0] rd_q;

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (cmd_i.push) begin
      tail_d = (tail_q == LastIdx) ? '0 : tail_q + 1'b1;
    end
    if (cmd_i.pop) begin
      head_d = (head_q == LastIdx) ? '0 : head_q + 1'b1;
    end
    if (cmd_i.push && !cmd_i.pop) begin
      count_d = count_q + 1'b1;
    end else if (cmd_i.pop && !cmd_i.push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      ring_mem[tail_q] <= push_slot_i;
    end
    rd_q <= ring_mem[head_q];
  end

  assign head_slot_o  = rd_q;
  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == FullCnt);

endmodule

/* rtl/psa_slot_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psa_slot_table: process slot storage and allocation
// Holds process id and table base per slot in one memory. Slots never return
// to unused, so they are handed out in ascending order by a fill counter;
// once every slot has been handed out, slot 0 is reused.
// ----------------------------------------------------------------------------
module psa_slot_table #(
  parameter int SLOTS = psa_pkg::SlotsDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     wr_en_i,
  input  logic [31:0]              wr_proc_id_i,
  input  logic [31:0]              wr_base_i,
  output logic [$clog2(SLOTS)-1:0] pick_o,
  output logic                     reused_o,
  input  logic [$clog2(SLOTS)-1:0] rd_addr_i,
  output logic [31:0]              rd_proc_id_o,
  output logic [31:0]              rd_base_o
);

  localparam int SlotW = $clog2(SLOTS);
  localparam int CntW  = $clog2(SLOTS + 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(SLOTS);

  logic [63:0]     tbl_mem [SLOTS];
  logic [63:0]     rd_q;
  logic [CntW-1:0] alloc_q, alloc_d;

  assign reused_o = (alloc_q == FullCnt);
  assign pick_o   = reused_o ? '0 : alloc_q[SlotW-1:0];

  always_comb begin
    alloc_d = alloc_q;
    if (wr_en_i && !reused_o) begin
      alloc_d = alloc_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alloc_q <= '0;
    end else begin
      alloc_q <= alloc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      tbl_mem[pick_o] <= {wr_proc_id_i, wr_base_i};
    end
    rd_q <= tbl_mem[rd_addr_i];
  end

  assign rd_proc_id_o = rd_q[63:32];
  assign rd_base_o    = rd_q[31:0];

endmodule

/* rtl/process_slot_allocator_ready_queue_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// process_slot_allocator_ready_queue_unit: process slots with a ready FIFO
// Command transactions arrive on in_i, one result transaction per command
// leaves on res_o.
//
// A create command takes the next unused slot (slot 0 once all are used),
// stamps it with the running id counter and the given table base and queues
// it. A dispatch command pops the oldest queued slot and returns its id and
// table base. Create on a full queue and dispatch on an empty one change
// nothing and report a status code.
//
// One command is in work at a time. A create goes from acceptance straight
// to S_DONE, which loads the result register; a dispatch passes S_LOOK
// first for the chained reads of the ring memory and then the slot table
// memory. Each command returns to S_IDLE before the next acceptance. The
// result register lets the next command be accepted while a result waits;
// a stalled receiver holds the command in its final step until the register
// frees up.
// After reset all slots are unused, the queue is empty and ids start at 0.
// ----------------------------------------------------------------------------
module process_slot_allocator_ready_queue_unit #(
  parameter int SLOTS = psa_pkg::SlotsDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  psa_in_if.sink          in_i,
  psa_out_if.source       res_o
);

  localparam int SlotW = $clog2(SLOTS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_DONE
  } state_e;

  state_e              state_q;
  psa_pkg::cmd_e       cmd_q;
  logic [31:0]         base_q;
  logic [31:0]         next_id_q;

  logic                out_valid_q;
  logic [SlotW-1:0]    out_slot_q;
  logic [31:0]         out_pid_q;
  logic [31:0]         out_base_q;
  psa_pkg::status_e    out_status_q;

  psa_pkg::ring_cmd_t  ring_cmd;
  psa_pkg::ring_stat_t ring_stat;
  logic [SlotW-1:0]    head_slot;
  logic [SlotW-1:0]    pick;
  logic                reused;
  logic [31:0]         tbl_pid;
  logic [31:0]         tbl_base;

  logic                in_acc;
  logic                out_free;
  logic                fire;
  logic                is_create;

  logic [SlotW-1:0]    res_slot;
  logic [31:0]         res_pid;
  logic [31:0]         res_base;
  psa_pkg::status_e    res_status;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || res_o.ready;
  assign fire       = (state_q == S_DONE) && out_free;
  assign is_create  = (cmd_q == psa_pkg::CMD_CREATE);

  assign ring_cmd.push = fire && is_create && !ring_stat.full;
  assign ring_cmd.pop  = fire && !is_create && !ring_stat.empty;

  psa_ready_ring #(
    .SLOTS(SLOTS)
  ) u_ring (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (ring_cmd),
    .push_slot_i(pick),
    .head_slot_o(head_slot),
    .stat_o     (ring_stat)
  );

  psa_slot_table #(
    .SLOTS(SLOTS)
  ) u_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (ring_cmd.push),
    .wr_proc_id_i(next_id_q),
    .wr_base_i   (base_q),
    .pick_o      (pick),
    .reused_o    (reused),
    .rd_addr_i   (head_slot),
    .rd_proc_id_o(tbl_pid),
    .rd_base_o   (tbl_base)
  );

  always_comb begin
    res_slot   = '0;
    res_pid    = '0;
    res_base   = '0;
    res_status = psa_pkg::STAT_OK;
    if (is_create) begin
      res_base = base_q;
      if (ring_stat.full) begin
        res_status = psa_pkg::STAT_FULL;
      end else begin
        res_slot   = pick;
        res_pid    = next_id_q;
        res_status = reused ? psa_pkg::STAT_REUSED : psa_pkg::STAT_OK;
      end
    end else if (ring_stat.empty) begin
      res_status = psa_pkg::STAT_EMPTY;
    end else begin
      res_slot = head_slot;
      res_pid  = tbl_pid;
      res_base = tbl_base;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cmd_q        <= psa_pkg::CMD_CREATE;
      base_q       <= '0;
      next_id_q    <= '0;
      out_valid_q  <= 1'b0;
      out_slot_q   <= '0;
      out_pid_q    <= '0;
      out_base_q   <= '0;
      out_status_q <= psa_pkg::STAT_OK;
    end else begin
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            cmd_q  <= psa_pkg::cmd_e'(in_i.cmd);
            base_q <= in_i.table_base;
            // Dispatch passes through S_LOOK for the slot table read.
            state_q <= (psa_pkg::cmd_e'(in_i.cmd) == psa_pkg::CMD_CREATE) ? S_DONE : S_LOOK;
          end
        end
        S_LOOK: begin
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_slot_q   <= res_slot;
            out_pid_q    <= res_pid;
            out_base_q   <= res_base;
            out_status_q <= res_status;
            if (ring_cmd.push) begin
              next_id_q <= next_id_q + 32'd1;
            end
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.slot            = out_slot_q;
  assign res_o.proc_id         = out_pid_q;
  assign res_o.slot_table_base = out_base_q;
  assign res_o.status          = out_status_q;

  a_ring_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ring_stat.full && ring_stat.empty))
    else $error("ready ring reports full and empty at once");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_cmd.pop |-> !ring_stat.empty)
    else $error("pop from an empty ready ring");

  a_push_nonfull: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_cmd.push |-> !ring_stat.full)
    else $error("push into a full ready ring");

  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_i.ready)
    else $error("second transaction accepted while one is in work");

  a_result_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q && (state_q == S_IDLE))
    else $error("finished command did not load the result register");

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench of the process slot allocator with ready queue
// Create and dispatch transactions go in through the command channel, and a
// running copy of the slot table and the ready ring predicts every result.
// Each result transaction is checked field by field against the oldest
// prediction. Both channels idle in random bursts except in the final part.
// ----------------------------------------------------------------------------
module tb;

  localparam int NumSlots    = 16;
  localparam int RandomItems = 1000;
  localparam int QuietItems  = 150;
  localparam int CycleLimit  = 400000;

  typedef enum logic [1:0] {
    SLOT_UNUSED  = 2'd0,
    SLOT_READY   = 2'd1,
    SLOT_RUNNING = 2'd2
  } slot_state_e;

  typedef struct packed {
    logic [3:0]       slot;
    logic [31:0]      proc_id;
    logic [31:0]      table_base;
    psa_pkg::status_e status;
  } psa_result_t;

  logic clk;
  logic rst_n;

  psa_in_if                 in_if ();
  psa_out_if #(.SLOT_W(4))  res_if ();

  process_slot_allocator_ready_queue_unit #(
    .SLOTS (NumSlots)
  ) dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .res_o  (res_if)
  );

  // Shadow copy of the block's slot table and ready ring.
  slot_state_e slot_state_q [NumSlots];
  logic [31:0] slot_pid_q   [NumSlots];
  logic [31:0] slot_base_q  [NumSlots];
  logic [3:0]  ring_q       [NumSlots];
  logic [3:0]  ring_head_q;
  logic [3:0]  ring_tail_q;
  logic [4:0]  ring_count_q;
  logic [31:0] next_pid_q;

  psa_result_t pending_results [$];

  int  error_count;
  int  cycle_count;
  int  create_count;
  int  dispatch_count;
  int  status_seen [4];
  bit  idle_en;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CycleLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Works out the result of one accepted command and advances the shadow state.
  task automatic predict_slot_result(input psa_pkg::cmd_e cmd, input logic [31:0] base);
    psa_result_t res;
    logic [3:0]  pick;
    bit          found;
    found = 1'b0;
    pick  = '0;
    if (cmd == psa_pkg::CMD_CREATE) begin
      create_count++;
      if (ring_count_q >= NumSlots) begin
        res = '{slot: 4'd0, proc_id: 32'd0, table_base: base, status: psa_pkg::STAT_FULL};
      end else begin
        for (int i = 0; i < NumSlots; i++) begin
          if (!found && slot_state_q[i] == SLOT_UNUSED) begin
            pick  = 4'(i);
            found = 1'b1;
          end
        end
        slot_pid_q[pick]   = next_pid_q;
        slot_base_q[pick]  = base;
        slot_state_q[pick] = SLOT_READY;
        ring_q[ring_tail_q] = pick;
        ring_tail_q  = ring_tail_q + 4'd1;
        ring_count_q = ring_count_q + 5'd1;
        res = '{slot: pick, proc_id: next_pid_q, table_base: base,
                status: found ? psa_pkg::STAT_OK : psa_pkg::STAT_REUSED};
        next_pid_q = next_pid_q + 32'd1;
      end
    end else begin
      dispatch_count++;
      if (ring_count_q == 0) begin
        res = '{slot: 4'd0, proc_id: 32'd0, table_base: 32'd0,
                status: psa_pkg::STAT_EMPTY};
      end else begin
        pick = ring_q[ring_head_q];
        ring_head_q  = ring_head_q + 4'd1;
        ring_count_q = ring_count_q - 5'd1;
        slot_state_q[pick] = SLOT_RUNNING;
        res = '{slot: pick, proc_id: slot_pid_q[pick], table_base: slot_base_q[pick],
                status: psa_pkg::STAT_OK};
      end
    end
    pending_results.push_back(res);
  endtask

  // Sends one command transaction and records its prediction once accepted.
  task automatic send_command(input psa_pkg::cmd_e cmd, input logic [31:0] base);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.cmd        <= cmd;
    in_if.table_base <= base;
    do @(posedge clk); while (!in_if.ready);
    predict_slot_result(cmd, base);
  endtask

  // Result sink with random back-pressure.
  initial begin
    res_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (idle_en && $urandom_range(0, 4) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    psa_result_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with no prediction pending: slot %0d status %0d",
               res_if.slot, res_if.status);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        status_seen[want.status]++;
        if (res_if.slot !== want.slot) begin
          $error("slot: expected %0d, got %0d", want.slot, res_if.slot);
          error_count++;
        end
        if (res_if.proc_id !== want.proc_id) begin
          $error("proc_id: expected 0x%08h, got 0x%08h", want.proc_id, res_if.proc_id);
          error_count++;
        end
        if (res_if.slot_table_base !== want.table_base) begin
          $error("slot_table_base: expected 0x%08h, got 0x%08h",
                 want.table_base, res_if.slot_table_base);
          error_count++;
        end
        if (res_if.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, res_if.status);
          error_count++;
        end
      end
    end
  end

  task automatic test_dispatch_when_empty();
    // The table base of a dispatch is ignored, so all ones must not leak out.
    send_command(psa_pkg::CMD_DISPATCH, 32'hFFFF_FFFF);
  endtask

  task automatic test_fill_queue();
    logic [31:0] base;
    for (int i = 0; i < NumSlots; i++) begin
      case (i)
        0:       base = 32'h0000_0000;
        1:       base = 32'hFFFF_FFFF;
        2:       base = 32'hAAAA_AAAA;
        3:       base = 32'h5555_5555;
        default: base = $urandom();
      endcase
      send_command(psa_pkg::CMD_CREATE, base);
    end
    // The queue now holds every slot, so this create is refused.
    send_command(psa_pkg::CMD_CREATE, 32'hDEAD_BEEF);
  endtask

  task automatic test_reuse_slot_zero();
    send_command(psa_pkg::CMD_DISPATCH, 32'h0);
    send_command(psa_pkg::CMD_DISPATCH, 32'h0);
    // No slot is unused any more, so both creates overwrite slot 0.
    send_command(psa_pkg::CMD_CREATE, 32'h1234_5678);
    send_command(psa_pkg::CMD_CREATE, 32'hFFFF_FFFF);
    send_command(psa_pkg::CMD_DISPATCH, 32'h0);
    send_command(psa_pkg::CMD_DISPATCH, 32'h0);
  endtask

  task automatic test_random_mix();
    int            create_pct;
    psa_pkg::cmd_e cmd;
    logic [31:0]   base;
    create_pct = 50;
    for (int i = 0; i < RandomItems; i++) begin
      // Runs biased toward create or dispatch drive the ring to full and empty.
      if (i % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       create_pct = 20;
          1:       create_pct = 50;
          default: create_pct = 85;
        endcase
      end
      if (i == RandomItems - QuietItems) idle_en = 1'b0;
      cmd = ($urandom_range(0, 99) < create_pct) ? psa_pkg::CMD_CREATE
                                                 : psa_pkg::CMD_DISPATCH;
      case ($urandom_range(0, 9))
        0:       base = 32'h0000_0000;
        1:       base = 32'hFFFF_FFFF;
        default: base = $urandom();
      endcase
      send_command(cmd, base);
    end
  endtask

  initial begin
    error_count    = 0;
    create_count   = 0;
    dispatch_count = 0;
    status_seen    = '{default: 0};
    idle_en        = 1'b1;
    for (int i = 0; i < NumSlots; i++) begin
      slot_state_q[i] = SLOT_UNUSED;
      slot_pid_q[i]   = '0;
      slot_base_q[i]  = '0;
      ring_q[i]       = '0;
    end
    ring_head_q  = '0;
    ring_tail_q  = '0;
    ring_count_q = '0;
    next_pid_q   = '0;

    rst_n            <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.cmd        <= psa_pkg::CMD_CREATE;
    in_if.table_base <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_dispatch_when_empty();
    test_fill_queue();
    test_reuse_slot_zero();
    test_random_mix();

    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d creates and %0d dispatches through fill, reuse and random runs.",
             create_count, dispatch_count);
    $display("Results by status: ok %0d, reused %0d, empty %0d, full %0d.",
             status_seen[psa_pkg::STAT_OK], status_seen[psa_pkg::STAT_REUSED],
             status_seen[psa_pkg::STAT_EMPTY], status_seen[psa_pkg::STAT_FULL]);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
